### src/assert_macros.svh
// Assertion macros shared by the neighbor group pooling modules.
// Each macro checks a property on the rising clock edge, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define NGP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle.
`define NGP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/ngp_pkg.sv
// Package for the neighbor group pooling block: register indexes and the
// command and status bundles between controller and datapath. No dependencies.
package ngp_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEIGHBOR_COUNT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_COUNT   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POOL_MODE      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAYOUT_ORDER   = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // latch the item and advance the position counters
      logic mem_read;   // read the slot entry
      logic update;     // compare, accumulate and write back
      logic src_a;      // first source index product
      logic src_b;      // second source index product
      logic div_start;  // start the averaging divider
      logic load_out;   // load the result register
   } ngp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_n;     // current item is the last neighbor of its slot
      logic avg_mode;   // average pooling selected
      logic div_busy;   // divider is iterating
      logic div_done;   // divider finished in the previous cycle
      logic out_free;   // result register can take a new result
   } ngp_status_type;

endpackage

### src/ngp_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating
// toward zero. Depends on assert_macros.svh.
`include "assert_macros.svh"

module ngp_div #(
   parameter int DW = 22,   // dividend width
   parameter int KW = 7,    // divisor width
   parameter int QW = 16    // quotient width delivered
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DW-1:0]        dividend,
   input  logic [KW-1:0]        divisor,
   output logic                 busy,
   output logic                 done,
   output logic [QW-1:0]        quotient
);

   localparam int CNTW = $clog2(DW + 1);

   logic [DW-1:0]   mag_ff, mag_in;
   logic [KW-1:0]   rem_ff, rem_in;
   logic [KW-1:0]   div_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            neg_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [KW:0]     trial;
   logic            fits;
   logic [DW-1:0]   signed_q;

   // One restoring step: shift in the next dividend bit and try the subtract.
   always_comb begin
      trial  = {rem_ff, mag_ff[DW-1]};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? KW'(trial - {1'b0, div_ff}) : trial[KW-1:0];
      mag_in = {mag_ff[DW-2:0], fits};
   end

   // Control: counter, busy and done flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNTW'(DW);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != CNTW'(1));
         done_ff <= (cnt_ff == CNTW'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   // Operands and partial results.
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[DW-1];
         mag_ff <= dividend[DW-1] ? DW'(-dividend) : dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         mag_ff <= mag_in;
         rem_ff <= rem_in;
      end
   end

   // Restore the sign of the quotient.
   assign signed_q = neg_ff ? DW'(-mag_ff) : mag_ff;
   assign quotient = signed_q[QW-1:0];
   assign busy     = busy_ff;
   assign done     = done_ff;

   `NGP_ASSERT_NEXT(a_div_finish, clock, reset, busy_ff && cnt_ff == CNTW'(1), done_ff && !busy_ff,
      "divider did not finish after its last step")
   `NGP_ASSERT_SAME(a_div_done_idle, clock, reset, done_ff, !busy_ff,
      "divider reports done while still iterating")

endmodule

### src/ngp_datapath.sv
// Datapath of the neighbor group pooling block: configuration registers,
// position counters, slot memory, index products and result register.
// Depends on ngp_pkg, ngp_div and assert_macros.svh.
`include "assert_macros.svh"

module ngp_datapath
   import ngp_pkg::*;
#(
   parameter int MAX_NEIGHBORS = 64,
   parameter int MAX_CHANNELS  = 256,
   parameter int MAX_SAMPLES   = 64,
   parameter int VALUE_BITS    = 16,
   parameter int CSR_W         = 9,
   parameter int INDEX_BITS    = 14,
   parameter int SOURCE_BITS   = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ngp_cmd_type               cmd,
   output ngp_status_type            stat,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_W-1:0]          csr_wdata,
   input  logic [VALUE_BITS-1:0]     in_value,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [VALUE_BITS-1:0]     rsp_pooled,
   output logic [INDEX_BITS-1:0]     rsp_index,
   output logic [SOURCE_BITS-1:0]    rsp_source,
   output logic                      rsp_last
);

   localparam int NB = $clog2(MAX_NEIGHBORS);
   localparam int CB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int SB = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int KW = $clog2(MAX_NEIGHBORS + 1);
   localparam int CW = $clog2(MAX_CHANNELS + 1);
   localparam int SW = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_BITS = VALUE_BITS + NB;
   localparam int DEPTH = MAX_SAMPLES * MAX_CHANNELS;
   localparam int PW = $clog2(MAX_NEIGHBORS * MAX_SAMPLES);
   localparam int EW = VALUE_BITS + NB + SUM_BITS;

   // Configuration registers.
   logic [KW-1:0] neighbor_count_ff;
   logic [CW-1:0] channel_count_ff;
   logic [SW-1:0] sample_count_ff;
   logic          pool_mode_ff;
   logic          layout_order_ff;

   logic [KW-1:0] eff_k;
   logic [CW-1:0] eff_ch;
   logic [SW-1:0] eff_sm;

   // Position counters.
   logic [SB-1:0] s_pos_ff, s_pos_in;
   logic [NB-1:0] n_pos_ff, n_pos_in;
   logic [CB-1:0] c_pos_ff, c_pos_in;
   logic          last_c, last_n, last_s;

   // Latched item.
   logic [VALUE_BITS-1:0] value_ff;
   logic [SB-1:0]         item_s_ff;
   logic [NB-1:0]         item_n_ff;
   logic [CB-1:0]         item_c_ff;
   logic                  item_last_c_ff, item_last_n_ff, item_last_s_ff;
   logic [INDEX_BITS-1:0] slot_ff;
   logic [SB+CW:0]        slot_full;

   // Slot memory and its read port.
   logic [EW-1:0]         pool_mem_ff [DEPTH];
   logic [EW-1:0]         rd_data_ff;
   logic [VALUE_BITS-1:0] rd_best;
   logic [NB-1:0]         rd_nbr;
   logic [SUM_BITS-1:0]   rd_sum;

   // Updated slot values.
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic [NB-1:0]         nbr_ff, nbr_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [SUM_BITS-1:0]   value_ext;

   // Source index products.
   logic [NB-1:0]           n_sel;
   logic [NB+SB+KW+SW:0]    part_full;
   logic [PW-1:0]           part_ff;
   logic [PW+CW:0]          src_full;
   logic [SOURCE_BITS-1:0]  src_ff;

   // Divider.
   logic                  div_busy, div_done;
   logic [VALUE_BITS-1:0] div_q;

   // Result register.
   logic                   rsp_valid_ff;
   logic [VALUE_BITS-1:0]  rsp_pooled_ff;
   logic [INDEX_BITS-1:0]  rsp_index_ff;
   logic [SOURCE_BITS-1:0] rsp_source_ff;
   logic                   rsp_last_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         neighbor_count_ff <= KW'(1);
         channel_count_ff  <= CW'(1);
         sample_count_ff   <= SW'(1);
         pool_mode_ff      <= 1'b0;
         layout_order_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NEIGHBOR_COUNT: neighbor_count_ff <= csr_wdata[KW-1:0];
            CSR_CHANNEL_COUNT:  channel_count_ff  <= csr_wdata[CW-1:0];
            CSR_SAMPLE_COUNT:   sample_count_ff   <= csr_wdata[SW-1:0];
            CSR_POOL_MODE:      pool_mode_ff      <= csr_wdata[0];
            CSR_LAYOUT_ORDER:   layout_order_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // A count of zero acts as one; a count above its maximum acts as the maximum.
   always_comb begin
      eff_k = (neighbor_count_ff == '0) ? KW'(1) :
              (neighbor_count_ff > KW'(MAX_NEIGHBORS)) ? KW'(MAX_NEIGHBORS) :
              neighbor_count_ff;
      eff_ch = (channel_count_ff == '0) ? CW'(1) :
               (channel_count_ff > CW'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) :
               channel_count_ff;
      eff_sm = (sample_count_ff == '0) ? SW'(1) :
               (sample_count_ff > SW'(MAX_SAMPLES)) ? SW'(MAX_SAMPLES) :
               sample_count_ff;
   end

   // Position of the incoming item and the counters after it.
   always_comb begin
      last_c = ({{(CW+1-CB){1'b0}}, c_pos_ff} + 1'b1) >= {1'b0, eff_ch};
      last_n = ({{(KW+1-NB){1'b0}}, n_pos_ff} + 1'b1) >= {1'b0, eff_k};
      last_s = ({{(SW+1-SB){1'b0}}, s_pos_ff} + 1'b1) >= {1'b0, eff_sm};
      s_pos_in = s_pos_ff;
      n_pos_in = n_pos_ff;
      c_pos_in = c_pos_ff + 1'b1;
      if (last_c) begin
         c_pos_in = '0;
         if (layout_order_ff) begin
            if (!last_s) begin
               s_pos_in = s_pos_ff + 1'b1;
            end else begin
               s_pos_in = '0;
               n_pos_in = last_n ? '0 : n_pos_ff + 1'b1;
            end
         end else begin
            if (!last_n) begin
               n_pos_in = n_pos_ff + 1'b1;
            end else begin
               n_pos_in = '0;
               s_pos_in = last_s ? '0 : s_pos_ff + 1'b1;
            end
         end
      end
   end

   assign slot_full = s_pos_ff * eff_ch + c_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_pos_ff <= '0;
         n_pos_ff <= '0;
         c_pos_ff <= '0;
      end else if (cmd.capture) begin
         s_pos_ff <= s_pos_in;
         n_pos_ff <= n_pos_in;
         c_pos_ff <= c_pos_in;
      end
   end

   // Item capture: value, position, and slot address.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         value_ff       <= in_value;
         item_s_ff      <= s_pos_ff;
         item_n_ff      <= n_pos_ff;
         item_c_ff      <= c_pos_ff;
         item_last_c_ff <= last_c;
         item_last_n_ff <= last_n;
         item_last_s_ff <= last_s;
         slot_ff        <= slot_full[INDEX_BITS-1:0];
      end
   end

   // Slot memory: registered read, write back of the updated entry.
   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_data_ff <= pool_mem_ff[slot_ff];
      end
      if (cmd.update) begin
         pool_mem_ff[slot_ff] <= {best_in, nbr_in, sum_in};
      end
   end

   assign rd_best = rd_data_ff[EW-1 -: VALUE_BITS];
   assign rd_nbr  = rd_data_ff[SUM_BITS +: NB];
   assign rd_sum  = rd_data_ff[SUM_BITS-1:0];

   // Max keeps the earliest largest value; the sum always accumulates.
   always_comb begin
      value_ext = {{NB{value_ff[VALUE_BITS-1]}}, value_ff};
      if (item_n_ff == '0) begin
         best_in = value_ff;
         nbr_in  = '0;
         sum_in  = value_ext;
      end else begin
         if ($signed(value_ff) > $signed(rd_best)) begin
            best_in = value_ff;
            nbr_in  = item_n_ff;
         end else begin
            best_in = rd_best;
            nbr_in  = rd_nbr;
         end
         sum_in = rd_sum + value_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         best_ff <= best_in;
         nbr_ff  <= nbr_in;
         sum_ff  <= sum_in;
      end
   end

   // Source index in two multiply stages.
   always_comb begin
      n_sel = pool_mode_ff ? item_n_ff : nbr_ff;
      if (layout_order_ff) begin
         part_full = n_sel * eff_sm + item_s_ff;
      end else begin
         part_full = item_s_ff * eff_k + n_sel;
      end
      src_full = part_ff * eff_ch + item_c_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.src_a) begin
         part_ff <= part_full[PW-1:0];
      end
      if (cmd.src_b) begin
         src_ff <= src_full[SOURCE_BITS-1:0];
      end
   end

   // Average: the slot sum divided by the neighbor count.
   ngp_div #(
      .DW(SUM_BITS),
      .KW(KW),
      .QW(VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (eff_k),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   // Result register, held until the transaction completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_pooled_ff <= pool_mode_ff ? div_q : best_ff;
         rsp_index_ff  <= slot_ff;
         rsp_source_ff <= src_ff;
         rsp_last_ff   <= item_last_c_ff && item_last_s_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pooled = rsp_pooled_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_source = rsp_source_ff;
   assign rsp_last   = rsp_last_ff;

   // Status to the controller.
   always_comb begin
      stat.last_n   = item_last_n_ff;
      stat.avg_mode = pool_mode_ff;
      stat.div_busy = div_busy;
      stat.div_done = div_done;
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   `NGP_ASSERT_NEXT(a_dp_load_valid, clock, reset, cmd.load_out, rsp_valid_ff,
      "result register not valid after a load")

endmodule

### src/ngp_ctrl.sv
// Controller of the neighbor group pooling block: sequences capture, slot
// read-modify-write, index products, division and result load.
// Depends on ngp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ngp_ctrl
   import ngp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  ngp_status_type stat,
   output ngp_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_SRC_A  = 3'd3;
   localparam logic [2:0] ST_SRC_B  = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   logic [2:0] state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = stat.last_n ? ST_SRC_A : ST_IDLE;
         end
         ST_SRC_A: begin
            cmd.src_a     = 1'b1;
            cmd.div_start = stat.avg_mode;
            state_in      = ST_SRC_B;
         end
         ST_SRC_B: begin
            cmd.src_b = 1'b1;
            state_in  = stat.avg_mode ? ST_DIV : ST_EMIT;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   `NGP_ASSERT_SAME(a_ctrl_capture_div_idle, clock, reset, cmd.capture, !stat.div_busy,
      "item taken while the divider is still busy")
   `NGP_ASSERT_NEXT(a_ctrl_div_started, clock, reset, cmd.div_start, stat.div_busy,
      "divider did not start when commanded")

endmodule

### src/neighbor_group_pooling.sv
// Neighbor group pooling top level; joins ngp_ctrl and ngp_datapath and uses ngp_pkg.
// An item that is not its slot's last neighbor passes through accept, slot read and write back.
// A last neighbor goes on through the first and second index products and the emit step, where
// the result register is loaded; average mode waits for the divider before the emit step.
// A stalled result holds the next last neighbor in its emit step until the register frees.
// Synchronous active-high reset clears registers and counters; the slot memory is not cleared.
module neighbor_group_pooling
   import ngp_pkg::*;
#(
   parameter int MAX_NEIGHBORS = 64,
   parameter int MAX_CHANNELS  = 256,
   parameter int MAX_SAMPLES   = 64,
   parameter int VALUE_BITS    = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // Input transaction.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0] req_tdata,   // value
   // Result transaction.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // pooled_value, output_index, source_index
   output logic [((VALUE_BITS
                   + ((MAX_SAMPLES*MAX_CHANNELS > 1) ?
                      $clog2(MAX_SAMPLES*MAX_CHANNELS) : 1)
                   + $clog2(MAX_SAMPLES*MAX_NEIGHBORS*MAX_CHANNELS)
                   + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                      rsp_tlast,   // batch_end
   // Configuration writes.
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [(($clog2(MAX_CHANNELS+1) > $clog2(MAX_NEIGHBORS+1)) ?
                  (($clog2(MAX_CHANNELS+1) > $clog2(MAX_SAMPLES+1)) ?
                   $clog2(MAX_CHANNELS+1) : $clog2(MAX_SAMPLES+1)) :
                  (($clog2(MAX_NEIGHBORS+1) > $clog2(MAX_SAMPLES+1)) ?
                   $clog2(MAX_NEIGHBORS+1) : $clog2(MAX_SAMPLES+1)))-1:0] csr_wdata
);

   localparam int KW = $clog2(MAX_NEIGHBORS + 1);
   localparam int CW = $clog2(MAX_CHANNELS + 1);
   localparam int SW = $clog2(MAX_SAMPLES + 1);
   localparam int CSR_W = (CW > KW) ? ((CW > SW) ? CW : SW) : ((KW > SW) ? KW : SW);
   localparam int INDEX_BITS = (MAX_SAMPLES * MAX_CHANNELS > 1) ?
                               $clog2(MAX_SAMPLES * MAX_CHANNELS) : 1;
   localparam int SOURCE_BITS = $clog2(MAX_SAMPLES * MAX_NEIGHBORS * MAX_CHANNELS);
   localparam int RSP_W = ((VALUE_BITS + INDEX_BITS + SOURCE_BITS + 7) / 8) * 8;

   ngp_cmd_type    cmd;
   ngp_status_type stat;

   logic [VALUE_BITS-1:0]  pooled_value;
   logic [INDEX_BITS-1:0]  output_index;
   logic [SOURCE_BITS-1:0] source_index;

   // Sequencing.
   ngp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   ngp_datapath #(
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .MAX_CHANNELS  (MAX_CHANNELS),
      .MAX_SAMPLES   (MAX_SAMPLES),
      .VALUE_BITS    (VALUE_BITS),
      .CSR_W         (CSR_W),
      .INDEX_BITS    (INDEX_BITS),
      .SOURCE_BITS   (SOURCE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_value   (req_tdata[VALUE_BITS-1:0]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_pooled (pooled_value),
      .rsp_index  (output_index),
      .rsp_source (source_index),
      .rsp_last   (rsp_tlast)
   );

   // Pack the result fields, lowest field first, zero filled to whole bytes.
   assign rsp_tdata = RSP_W'({source_index, output_index, pooled_value});

endmodule

### tb/sv/tb_neighbor_group_pooling.sv
// Self-checking testbench for neighbor_group_pooling: directed table, then random phases.
// Depends on ngp_pkg (register indexes) and the neighbor_group_pooling RTL only.
`timescale 1ns / 100ps

module tb_neighbor_group_pooling;
   import ngp_pkg::*;

   localparam int NEIGHBOR_LIMIT = 64;
   localparam int CHANNEL_LIMIT  = 256;
   localparam int SAMPLE_LIMIT   = 64;
   localparam int SLOT_COUNT     = SAMPLE_LIMIT * CHANNEL_LIMIT;
   localparam int SETTLE_CYCLES  = 40;
   localparam int QUIET_LIMIT    = 3000;
   localparam int RANDOM_ITEMS   = 820;

   // Mode and layout codes as the registers hold them.
   localparam logic POOL_MAX              = 1'b0;
   localparam logic POOL_AVG              = 1'b1;
   localparam logic LAYOUT_SAMPLE_MAJOR   = 1'b0;
   localparam logic LAYOUT_NEIGHBOR_MAJOR = 1'b1;

   typedef struct packed {
      logic [6:0] neighbors;
      logic [8:0] channels;
      logic [6:0] samples;
      logic       pool_avg;
      logic       neighbor_major;
   } pool_settings_type;

   typedef struct packed {
      logic [15:0] pooled;
      logic [13:0] out_index;
      logic [19:0] source;
      logic        batch_end;
   } pooled_result_type;

   // One row of directed stimulus: either a settings change or one feature value.
   typedef struct {
      bit                set_config;
      pool_settings_type settings;
      logic [15:0]       value;
      bit                typed;       // expectation is given in the row itself
      bit                typed_has;
      pooled_result_type typed_result;
   } stimulus_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [15:0]               req_tdata;    // value
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [55:0]               rsp_tdata;    // pooled_value, output_index, source_index
   logic                      rsp_tlast;    // batch_end
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [8:0]                csr_wdata;

   neighbor_group_pooling DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Register copy and pooling state of the predictor.
   pool_settings_type       shadow;
   int unsigned             pos_s, pos_n, pos_c;
   logic signed [15:0]      slot_max    [SLOT_COUNT];
   logic [5:0]              slot_max_nb [SLOT_COUNT];
   logic signed [21:0]      slot_sum    [SLOT_COUNT];

   pooled_result_type       expected_pools[$];
   stimulus_row_type        directed_rows[$];
   int                      mismatches;
   int                      items_sent;
   int                      results_seen;
   int                      settings_used;
   int                      quiet_cycles;
   int                      rsp_hold_left;
   bit                      steady_flow;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int effective_count(int raw, int top);
      if (raw == 0) return 1;
      if (raw > top) return top;
      return raw;
   endfunction

   // Flat input position of (sample, neighbor, channel) in the current layout.
   function automatic logic [19:0] source_position(int unsigned s, int unsigned n,
                                                   int unsigned c, int unsigned k,
                                                   int unsigned ch, int unsigned sm);
      if (shadow.neighbor_major) return 20'((n * sm + s) * ch + c);
      return 20'((s * k + n) * ch + c);
   endfunction

   // Folds one feature value into its slot; returns 1 when the slot completes.
   function automatic bit pool_feature(logic [15:0] raw, output pooled_result_type res);
      int unsigned k, ch, sm, s, n, c, slot;
      bit          last_c, last_n, last_s;
      int          v, total;
      k      = effective_count(int'(shadow.neighbors), NEIGHBOR_LIMIT);
      ch     = effective_count(int'(shadow.channels), CHANNEL_LIMIT);
      sm     = effective_count(int'(shadow.samples), SAMPLE_LIMIT);
      s      = pos_s;
      n      = pos_n;
      c      = pos_c;
      last_c = (c + 1 >= ch);
      last_n = (n + 1 >= k);
      last_s = (s + 1 >= sm);
      v      = $signed(raw);
      slot   = (s * ch + c) % SLOT_COUNT;
      res    = '0;

      // Both the maximum and the sum track every value; ties keep the earliest.
      if (n == 0) begin
         slot_max[slot]    = raw;
         slot_max_nb[slot] = '0;
         slot_sum[slot]    = 22'(v);
      end else begin
         if (v > int'(slot_max[slot])) begin
            slot_max[slot]    = raw;
            slot_max_nb[slot] = 6'(n);
         end
         slot_sum[slot] = slot_sum[slot] + 22'(v);
      end

      if (last_n) begin
         if (shadow.pool_avg) begin
            total      = slot_sum[slot];
            res.pooled = 16'(total / int'(k));
            res.source = source_position(s, n, c, k, ch, sm);
         end else begin
            res.pooled = slot_max[slot];
            res.source = source_position(s, slot_max_nb[slot], c, k, ch, sm);
         end
         res.out_index = 14'(s * ch + c);
         res.batch_end = last_c && last_s;
      end

      // Channel runs fastest; the layout decides whether sample or neighbor comes next.
      if (!last_c) begin
         pos_c = c + 1;
      end else begin
         pos_c = 0;
         if (shadow.neighbor_major) begin
            if (!last_s) begin
               pos_s = s + 1;
            end else begin
               pos_s = 0;
               pos_n = last_n ? 0 : n + 1;
            end
         end else begin
            if (!last_n) begin
               pos_n = n + 1;
            end else begin
               pos_n = 0;
               pos_s = last_s ? 0 : s + 1;
            end
         end
      end
      return last_n;
   endfunction

   function automatic stimulus_row_type settings_row(logic [6:0] k, logic [8:0] ch,
                                                     logic [6:0] sm, logic avg, logic nmajor);
      stimulus_row_type row;
      row            = '{default: '0};
      row.set_config = 1'b1;
      row.settings   = '{k, ch, sm, avg, nmajor};
      return row;
   endfunction

   function automatic stimulus_row_type value_row(logic [15:0] v);
      stimulus_row_type row;
      row       = '{default: '0};
      row.value = v;
      return row;
   endfunction

   function automatic stimulus_row_type typed_row(logic [15:0] v, bit has, logic [15:0] pooled,
                                                  logic [13:0] oi, logic [19:0] src,
                                                  logic last);
      stimulus_row_type row;
      row              = value_row(v);
      row.typed        = 1'b1;
      row.typed_has    = has;
      row.typed_result = '{pooled, oi, src, last};
      return row;
   endfunction

   // Settings for the phases that push each count to its limits.
   function automatic pool_settings_type extreme_settings(int idx);
      case (idx)
         0:       return '{7'd64, 9'd1, 7'd1, POOL_MAX, LAYOUT_SAMPLE_MAJOR};
         1:       return '{7'd100, 9'd1, 7'd2, POOL_AVG, LAYOUT_NEIGHBOR_MAJOR};
         2:       return '{7'd1, 9'd511, 7'd1, POOL_MAX, LAYOUT_NEIGHBOR_MAJOR};
         3:       return '{7'd1, 9'd0, 7'd64, POOL_AVG, LAYOUT_NEIGHBOR_MAJOR};
         4:       return '{7'd2, 9'd1, 7'd100, POOL_MAX, LAYOUT_SAMPLE_MAJOR};
         default: return '{7'd3, 9'd2, 7'd0, POOL_AVG, LAYOUT_SAMPLE_MAJOR};
      endcase
   endfunction

   // Mostly back-to-back, sometimes a short gap, rarely a long one.
   function automatic int idle_gap();
      int pick;
      if (steady_flow) return 0;
      pick = $urandom_range(0, 19);
      if (pick < 12) return 0;
      if (pick < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random feature value: full range, small magnitudes, extremes and repeats for ties.
   function automatic logic [15:0] random_feature(logic [15:0] prev);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom);
         4, 5:       return 16'($urandom_range(0, 1023) - 512);
         6:          return 16'h7FFF;
         7:          return 16'h8000;
         default:    return prev;
      endcase
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Sends one input transaction and records what it should produce.
   task automatic send_item(input stimulus_row_type row);
      int                gap;
      bit                has;
      pooled_result_type res;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.value;
      do @(posedge clock); while (req_tready !== 1'b1);
      has = pool_feature(row.value, res);
      if (row.typed) begin
         has = row.typed_has;
         res = row.typed_result;
      end
      if (has) expected_pools.push_back(res);
      items_sent++;
   endtask

   // Holds the sender until every pending result is back, then optionally lets
   // an item with no result finish its memory update.
   task automatic wait_idle(input bit settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_pools.size() != 0);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_settings(input pool_settings_type cfg);
      csr_we    <= 1'b1;
      csr_index <= CSR_NEIGHBOR_COUNT;
      csr_wdata <= 9'(cfg.neighbors);
      @(posedge clock);
      csr_index <= CSR_CHANNEL_COUNT;
      csr_wdata <= cfg.channels;
      @(posedge clock);
      csr_index <= CSR_SAMPLE_COUNT;
      csr_wdata <= 9'(cfg.samples);
      @(posedge clock);
      csr_index <= CSR_POOL_MODE;
      csr_wdata <= 9'(cfg.pool_avg);
      @(posedge clock);
      csr_index <= CSR_LAYOUT_ORDER;
      csr_wdata <= 9'(cfg.neighbor_major);
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow = cfg;
      settings_used++;
   endtask

   // Result side: random stalls of varying length.
   always @(posedge clock) begin
      int gap;
      if (rsp_hold_left > 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         gap = ($urandom_range(0, 2) == 0) ? idle_gap() : 0;
         if (gap > 0) begin
            rsp_tready    <= 1'b0;
            rsp_hold_left <= gap - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each result transaction with the oldest pending expectation.
   always @(posedge clock) begin
      pooled_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (expected_pools.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h last %0b",
                     $time, rsp_tdata[49:0], rsp_tlast);
            mismatches++;
         end else begin
            want = expected_pools.pop_front();
            compare_field("pooled_value", 32'(want.pooled), 32'(rsp_tdata[15:0]));
            compare_field("output_index", 32'(want.out_index), 32'(rsp_tdata[29:16]));
            compare_field("source_index", 32'(want.source), 32'(rsp_tdata[49:30]));
            compare_field("batch_end", 32'(want.batch_end), 32'(rsp_tlast));
         end
         results_seen++;
      end
   end

   // Count cycles in which no transaction or register write takes place.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      pool_settings_type cfg;
      logic [15:0]       prev;
      int                phase, batches, per_batch, random_items, k, ch, sm;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_NEIGHBOR_COUNT;
      csr_wdata     = '0;
      rsp_hold_left = 0;
      quiet_cycles  = 0;
      steady_flow   = 1'b0;
      mismatches    = 0;
      items_sent    = 0;
      results_seen  = 0;
      settings_used = 0;
      random_items  = 0;
      prev          = '0;
      shadow        = '{7'd1, 9'd1, 7'd1, POOL_MAX, LAYOUT_SAMPLE_MAJOR};
      pos_s         = 0;
      pos_n         = 0;
      pos_c         = 0;

      // Reset settings pass each value straight through as the whole batch.
      directed_rows.push_back(typed_row(16'h7FFF, 1'b1, 16'h7FFF, 14'd0, 20'd0, 1'b1));
      directed_rows.push_back(typed_row(16'h8000, 1'b1, 16'h8000, 14'd0, 20'd0, 1'b1));
      directed_rows.push_back(typed_row(16'h0000, 1'b1, 16'h0000, 14'd0, 20'd0, 1'b1));
      directed_rows.push_back(typed_row(16'hFFFF, 1'b1, 16'hFFFF, 14'd0, 20'd0, 1'b1));
      directed_rows.push_back(typed_row(16'h5A5A, 1'b1, 16'h5A5A, 14'd0, 20'd0, 1'b1));
      // A neighbor count of zero acts as one, in both modes.
      directed_rows.push_back(settings_row(7'd0, 9'd1, 7'd1, POOL_MAX, LAYOUT_SAMPLE_MAJOR));
      directed_rows.push_back(typed_row(16'h1234, 1'b1, 16'h1234, 14'd0, 20'd0, 1'b1));
      directed_rows.push_back(settings_row(7'd0, 9'd1, 7'd1, POOL_AVG, LAYOUT_SAMPLE_MAJOR));
      directed_rows.push_back(typed_row(16'h8001, 1'b1, 16'h8001, 14'd0, 20'd0, 1'b1));
      // Three-way tie keeps the first neighbor; only the last neighbor gives a result.
      directed_rows.push_back(settings_row(7'd3, 9'd1, 7'd1, POOL_MAX, LAYOUT_SAMPLE_MAJOR));
      directed_rows.push_back(typed_row(16'h0005, 1'b0, 16'h0000, 14'd0, 20'd0, 1'b0));
      directed_rows.push_back(typed_row(16'h0005, 1'b0, 16'h0000, 14'd0, 20'd0, 1'b0));
      directed_rows.push_back(typed_row(16'h0005, 1'b1, 16'h0005, 14'd0, 20'd0, 1'b1));
      directed_rows.push_back(value_row(16'hFFFF));
      directed_rows.push_back(value_row(16'h0007));
      directed_rows.push_back(value_row(16'h0007));
      // A negative sum of -2 over three truncates toward zero.
      directed_rows.push_back(settings_row(7'd3, 9'd1, 7'd1, POOL_AVG, LAYOUT_SAMPLE_MAJOR));
      directed_rows.push_back(typed_row(16'hFFFF, 1'b0, 16'h0000, 14'd0, 20'd0, 1'b0));
      directed_rows.push_back(typed_row(16'hFFFF, 1'b0, 16'h0000, 14'd0, 20'd0, 1'b0));
      directed_rows.push_back(typed_row(16'h0000, 1'b1, 16'h0000, 14'd0, 20'd2, 1'b1));
      // Neighbor-major order over a 2x2x2 batch.
      directed_rows.push_back(settings_row(7'd2, 9'd2, 7'd2, POOL_MAX, LAYOUT_NEIGHBOR_MAJOR));
      directed_rows.push_back(value_row(16'h0100));
      directed_rows.push_back(value_row(16'hFF00));
      directed_rows.push_back(value_row(16'h8000));
      directed_rows.push_back(value_row(16'h7FFF));
      directed_rows.push_back(value_row(16'h0100));
      directed_rows.push_back(value_row(16'h0200));
      directed_rows.push_back(value_row(16'h7FFF));
      directed_rows.push_back(value_row(16'h8000));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_config) begin
            wait_idle(1'b1);
            program_settings(directed_rows[i].settings);
         end else begin
            send_item(directed_rows[i]);
         end
      end

      // Limit settings first, then random small batches; settings change only
      // between whole batches so every slot is written before it is read.
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (phase < 6) begin
            cfg     = extreme_settings(phase);
            batches = (phase == 0) ? 2 : (phase == 5) ? 4 : 1;
         end else begin
            k  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
            ch = $urandom_range(1, 6);
            sm = $urandom_range(1, 6);
            if (k * ch * sm > 150) ch = 1;
            cfg.neighbors      = (k == 1 && $urandom_range(0, 3) == 0) ? 7'd0 : 7'(k);
            cfg.channels       = (ch == 1 && $urandom_range(0, 3) == 0) ? 9'd0 : 9'(ch);
            cfg.samples        = (sm == 1 && $urandom_range(0, 3) == 0) ? 7'd0 : 7'(sm);
            cfg.pool_avg       = $urandom_range(0, 1) ? POOL_AVG : POOL_MAX;
            cfg.neighbor_major = $urandom_range(0, 1) ? LAYOUT_NEIGHBOR_MAJOR
                                                      : LAYOUT_SAMPLE_MAJOR;
            batches = $urandom_range(1, 3);
         end
         per_batch = effective_count(int'(cfg.neighbors), NEIGHBOR_LIMIT)
                   * effective_count(int'(cfg.channels), CHANNEL_LIMIT)
                   * effective_count(int'(cfg.samples), SAMPLE_LIMIT);
         wait_idle(1'b1);
         steady_flow = ($urandom_range(0, 3) == 0);
         program_settings(cfg);
         repeat (batches * per_batch) begin
            // Now and then the sender holds off until all results are back.
            if (items_sent % 97 == 50) wait_idle(1'b0);
            prev = random_feature(prev);
            send_item(value_row(prev));
            random_items++;
         end
         phase++;
      end

      wait_idle(1'b1);
      $display("Summary: %0d input and %0d result transactions over %0d register settings.",
               items_sent, results_seen, settings_used);
      $display("Summary: max and average pooling, both input orders, counts at and past limits.");
      if (mismatches == 0 && expected_pools.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
